FILE: hw/rtl/tch_pkg.sv
// tch_pkg: shared types and constants of the tilt-compensated heading unit
`default_nettype none

package tch_pkg;

	localparam int FIELD_W      = 16;
	localparam int CFG_INDEX_W  = 2;
	localparam int HW           = 51;
	localparam int MAG_W        = 50;
	localparam int NORM_W       = 41;
	localparam int XW           = 45;
	localparam int ZW           = 27;
	localparam int ANG_W        = 14;
	localparam int ANGLE_FRAC   = 12;
	localparam int CORDIC_STEPS = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Z = CFG_INDEX_W'(2);

	localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(36864000);
	localparam logic signed [ZW-1:0] ROUND_HALF   = ZW'(2048);
	localparam logic signed [FIELD_W-1:0] HALF_TURN_CD = FIELD_W'(18000);

	// atan(2^-i) in 1/4096 centidegree
	localparam logic signed [ZW-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
		ZW'(18432000), ZW'(10881045), ZW'(5749245), ZW'(2918407),
		ZW'(1464867), ZW'(733147), ZW'(366663), ZW'(183343),
		ZW'(91673), ZW'(45837), ZW'(22918), ZW'(11459),
		ZW'(5730), ZW'(2865), ZW'(1432), ZW'(716),
		ZW'(358), ZW'(179), ZW'(90), ZW'(45),
		ZW'(22), ZW'(11), ZW'(6), ZW'(3)
	};

	typedef struct packed {
		logic signed [FIELD_W-1:0] mag_x;
		logic signed [FIELD_W-1:0] mag_y;
		logic signed [FIELD_W-1:0] mag_z;
		logic signed [FIELD_W-1:0] acc_x;
		logic signed [FIELD_W-1:0] acc_y;
		logic signed [FIELD_W-1:0] acc_z;
	} sample_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] z;
	} offsets_t;

	typedef struct packed {
		logic accel_zero;
		logic h_zero;
		logic neg_x;
		logic neg_y;
	} flags_t;

	typedef struct packed {
		logic                 valid;
		logic                 accel_zero;
		logic signed [HW-1:0] hx;
		logic signed [HW-1:0] hy;
	} front_t;

	typedef struct packed {
		logic              valid;
		flags_t            flags;
		logic [NORM_W-1:0] cx;
		logic [NORM_W-1:0] sy;
	} norm_t;

	typedef struct packed {
		logic                      valid;
		logic                      accel_zero;
		logic signed [FIELD_W-1:0] heading;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tch_front.sv
// tch_front: hard-iron offset, dot products and horizontal components
`default_nettype none

module tch_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  tch_pkg::sample_t   sample,
	input  tch_pkg::offsets_t  offsets,
	output tch_pkg::front_t    out
);

	localparam int FW = tch_pkg::FIELD_W;
	localparam int MW = FW + 1;
	localparam int PW = MW + FW;
	localparam int QW = 2 * FW;
	localparam int DW = PW + 2;
	localparam int NW = QW + 1;
	localparam int AW = MW + NW;
	localparam int HW = tch_pkg::HW;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                 zero_s1, zero_s2, zero_s3, zero_s4, zero_s5;

	logic signed [MW-1:0] mx_s1, my_s1, mz_s1;
	logic signed [FW-1:0] ax_s1, ay_s1, az_s1;

	logic signed [PW-1:0] pmx_s2, pmy_s2, pmz_s2;
	logic signed [QW-1:0] qx_s2, qy_s2, qz_s2;
	logic signed [MW-1:0] mx_s2, my_s2;
	logic signed [FW-1:0] ax_s2, ay_s2;

	logic signed [DW-1:0] d_s3;
	logic signed [NW-1:0] n_s3;
	logic signed [MW-1:0] mx_s3, my_s3;
	logic signed [FW-1:0] ax_s3, ay_s3;

	logic signed [AW-1:0] pa_s4, pc_s4;
	logic signed [HW-1:0] pb_s4, pe_s4;

	logic signed [HW-1:0] hx_s5, hy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1   <= MW'(sample.mag_x) - MW'(offsets.x);
			my_s1   <= MW'(sample.mag_y) - MW'(offsets.y);
			mz_s1   <= MW'(sample.mag_z) - MW'(offsets.z);
			ax_s1   <= sample.acc_x;
			ay_s1   <= sample.acc_y;
			az_s1   <= sample.acc_z;
			zero_s1 <= (sample.acc_x == '0) && (sample.acc_y == '0) && (sample.acc_z == '0);

			pmx_s2  <= PW'(mx_s1) * PW'(ax_s1);
			pmy_s2  <= PW'(my_s1) * PW'(ay_s1);
			pmz_s2  <= PW'(mz_s1) * PW'(az_s1);
			qx_s2   <= QW'(ax_s1) * QW'(ax_s1);
			qy_s2   <= QW'(ay_s1) * QW'(ay_s1);
			qz_s2   <= QW'(az_s1) * QW'(az_s1);
			mx_s2   <= mx_s1;
			my_s2   <= my_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			zero_s2 <= zero_s1;

			d_s3    <= DW'(pmx_s2) + DW'(pmy_s2) + DW'(pmz_s2);
			n_s3    <= NW'(qx_s2) + NW'(qy_s2) + NW'(qz_s2);
			mx_s3   <= mx_s2;
			my_s3   <= my_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			zero_s3 <= zero_s2;

			pa_s4   <= AW'(mx_s3) * AW'(n_s3);
			pc_s4   <= AW'(my_s3) * AW'(n_s3);
			pb_s4   <= HW'(d_s3) * HW'(ax_s3);
			pe_s4   <= HW'(d_s3) * HW'(ay_s3);
			zero_s4 <= zero_s3;

			hx_s5   <= HW'(pa_s4) - pb_s4;
			hy_s5   <= HW'(pc_s4) - pe_s4;
			zero_s5 <= zero_s4;
		end
	end

	assign out.valid      = v_s5;
	assign out.accel_zero = zero_s5;
	assign out.hx         = hx_s5;
	assign out.hy         = hy_s5;

endmodule

`default_nettype wire

FILE: hw/rtl/tch_norm.sv
// tch_norm: magnitudes, sign and zero flags and normalizing shift ahead of the cordic
`default_nettype none

module tch_norm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tch_pkg::front_t  in,
	output tch_pkg::norm_t   out
);

	localparam int HW    = tch_pkg::HW;
	localparam int MAG_W = tch_pkg::MAG_W;
	localparam int NW    = tch_pkg::NORM_W;

	typedef struct packed {
		logic [MAG_W-1:0] big;
		logic [MAG_W-1:0] cx;
		logic [MAG_W-1:0] sy;
	} nrm_t;

	function automatic nrm_t nstep(input nrm_t a, input int k);
		nrm_t r;
		r = a;
		if ((a.big >> (MAG_W - k)) == '0) begin
			r.big = a.big << k;
			r.cx  = a.cx << k;
			r.sy  = a.sy << k;
		end
		return r;
	endfunction

	logic signed [HW-1:0] hx_abs, hy_abs;
	logic                 v_s1, v_s2, v_s3, v_s4;
	tch_pkg::flags_t      f_s1, f_s2, f_s3, f_s4;
	logic [MAG_W-1:0]     cx_s1, sy_s1;
	nrm_t                 w_s2, w_s3, w_s4;
	nrm_t                 step3, step4;

	always_comb begin
		hx_abs = in.hx[HW-1] ? -in.hx : in.hx;
		hy_abs = in.hy[HW-1] ? -in.hy : in.hy;
		step3  = nstep(nstep(nstep(w_s2, 32), 16), 8);
		step4  = nstep(nstep(nstep(w_s3, 4), 2), 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1           <= hy_abs[MAG_W-1:0];
			sy_s1           <= hx_abs[MAG_W-1:0];
			f_s1.accel_zero <= in.accel_zero;
			f_s1.h_zero     <= (in.hx == '0) && (in.hy == '0);
			f_s1.neg_x      <= in.hx[HW-1];
			f_s1.neg_y      <= in.hy[HW-1];

			w_s2.big        <= (cx_s1 > sy_s1) ? cx_s1 : sy_s1;
			w_s2.cx         <= cx_s1;
			w_s2.sy         <= sy_s1;
			f_s2            <= f_s1;

			w_s3            <= step3;
			f_s3            <= f_s2;

			w_s4            <= step4;
			f_s4            <= f_s3;
		end
	end

	assign out.valid = v_s4;
	assign out.flags = f_s4;
	assign out.cx    = w_s4.cx[MAG_W-1 -: NW];
	assign out.sy    = w_s4.sy[MAG_W-1 -: NW];

endmodule

`default_nettype wire

FILE: hw/rtl/tch_cordic.sv
// tch_cordic: vectoring cordic, one rotation per stage, with rounding and quadrant fix
`default_nettype none

module tch_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  tch_pkg::norm_t    in,
	output tch_pkg::result_t  out
);

	localparam int XW    = tch_pkg::XW;
	localparam int ZW    = tch_pkg::ZW;
	localparam int FW    = tch_pkg::FIELD_W;
	localparam int AGW   = tch_pkg::ANG_W;
	localparam int FRAC  = tch_pkg::ANGLE_FRAC;
	localparam int STEPS = tch_pkg::CORDIC_STEPS;

	logic signed [XW-1:0] xa [STEPS];
	logic signed [XW-1:0] ya [STEPS];
	logic signed [ZW-1:0] za [STEPS];
	tch_pkg::flags_t      fa [STEPS];
	logic                 va [STEPS];

	logic signed [XW-1:0] x_s [STEPS];
	logic signed [XW-1:0] y_s [STEPS];
	logic signed [ZW-1:0] z_s [STEPS];
	tch_pkg::flags_t      f_s [STEPS];
	logic                 v_s [STEPS];

	logic signed [ZW-1:0] z_clamp, z_round;
	logic [AGW-1:0]       ang_s25;
	tch_pkg::flags_t      f_s25;
	logic                 v_s25;

	logic signed [FW-1:0] head_a, head_b, head_c;
	logic signed [FW-1:0] head_s26;
	logic                 zero_s26;
	logic                 v_s26;

	always_comb begin
		for (int i = 0; i < STEPS; i++) begin
			if (i == 0) begin
				xa[i] = XW'(in.cx);
				ya[i] = XW'(in.sy);
				za[i] = '0;
				fa[i] = in.flags;
				va[i] = in.valid;
			end else begin
				xa[i] = x_s[i-1];
				ya[i] = y_s[i-1];
				za[i] = z_s[i-1];
				fa[i] = f_s[i-1];
				va[i] = v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STEPS; i++) begin
				v_s[i] <= 1'b0;
			end
			v_s25 <= 1'b0;
			v_s26 <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < STEPS; i++) begin
				v_s[i] <= va[i];
			end
			v_s25 <= v_s[STEPS-1];
			v_s26 <= v_s25;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < STEPS; i++) begin
				if (!ya[i][XW-1]) begin
					x_s[i] <= xa[i] + (ya[i] >>> i);
					y_s[i] <= ya[i] - (xa[i] >>> i);
					z_s[i] <= za[i] + tch_pkg::ATAN_TABLE[i];
				end else begin
					x_s[i] <= xa[i] - (ya[i] >>> i);
					y_s[i] <= ya[i] + (xa[i] >>> i);
					z_s[i] <= za[i] - tch_pkg::ATAN_TABLE[i];
				end
				f_s[i] <= fa[i];
			end
		end
	end

	// clamp to the first quadrant and round to centidegrees
	always_comb begin
		if (z_s[STEPS-1][ZW-1]) begin
			z_clamp = '0;
		end else if (z_s[STEPS-1] > tch_pkg::QUARTER_TURN) begin
			z_clamp = tch_pkg::QUARTER_TURN;
		end else begin
			z_clamp = z_s[STEPS-1];
		end
		z_round = z_clamp + tch_pkg::ROUND_HALF;
	end

	always_comb begin
		head_a = FW'(ang_s25);
		head_b = f_s25.neg_y ? (tch_pkg::HALF_TURN_CD - head_a) : head_a;
		head_c = f_s25.neg_x ? -head_b : head_b;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s25  <= z_round[FRAC+AGW-1:FRAC];
			f_s25    <= f_s[STEPS-1];

			head_s26 <= (f_s25.accel_zero || f_s25.h_zero) ? '0 : head_c;
			zero_s26 <= f_s25.accel_zero;
		end
	end

	assign out.valid      = v_s26;
	assign out.accel_zero = zero_s26;
	assign out.heading    = head_s26;

endmodule

`default_nettype wire

FILE: hw/rtl/tilt_compensated_heading_unit.sv
// tilt_compensated_heading_unit: top level with offset registers and output skid stage
// throughput: one request per cycle while s_tready is high; 35 pipeline stages (24 of them cordic) run on one enable
// a stalled output parks one result in a skid register, after which s_tready drops
// reset: arst_n clears all valid bits and sets the three offsets to zero
`default_nettype none

module tilt_compensated_heading_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// mag_x, mag_y, mag_z, acc_x, acc_y, acc_z
	input  logic [6*tch_pkg::FIELD_W-1:0]         s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// heading_centideg
	output logic [tch_pkg::FIELD_W-1:0]           m_tdata,
	// accel_zero
	output logic                                  m_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tch_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [tch_pkg::FIELD_W-1:0]           cfg_data
);

	localparam int FW = tch_pkg::FIELD_W;

	tch_pkg::offsets_t    off_q;
	tch_pkg::sample_t     sample;
	tch_pkg::front_t      front;
	tch_pkg::norm_t       norm;
	tch_pkg::result_t     res;

	logic                 en;
	logic                 take;
	logic                 out_valid_q, skid_valid_q;
	logic signed [FW-1:0] heading_q, skid_heading_q;
	logic                 az_q, skid_az_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tch_pkg::REG_OFFSET_X: off_q.x <= cfg_data;
				tch_pkg::REG_OFFSET_Y: off_q.y <= cfg_data;
				tch_pkg::REG_OFFSET_Z: off_q.z <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sample.mag_x = s_tdata[0*FW +: FW];
	assign sample.mag_y = s_tdata[1*FW +: FW];
	assign sample.mag_z = s_tdata[2*FW +: FW];
	assign sample.acc_x = s_tdata[3*FW +: FW];
	assign sample.acc_y = s_tdata[4*FW +: FW];
	assign sample.acc_z = s_tdata[5*FW +: FW];

	assign en       = !skid_valid_q;
	assign s_tready = en;

	tch_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.sample   (sample),
		.offsets  (off_q),
		.out      (front)
	);

	tch_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in     (front),
		.out    (norm)
	);

	tch_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in     (norm),
		.out    (res)
	);

	assign take = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || take) begin
			out_valid_q <= res.valid;
		end else if (res.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				heading_q <= skid_heading_q;
				az_q      <= skid_az_q;
			end
		end else if (!out_valid_q || take) begin
			heading_q <= res.heading;
			az_q      <= res.accel_zero;
		end else begin
			skid_heading_q <= res.heading;
			skid_az_q      <= res.accel_zero;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = heading_q;
	assign m_tuser  = az_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready))
		else $error("skid filled without a stalled output");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (heading_q >= -tch_pkg::HALF_TURN_CD && heading_q <= tch_pkg::HALF_TURN_CD))
		else $error("heading outside half a turn");

	a_zero_accel_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && az_q) |-> (heading_q == '0))
		else $error("zero accelerometer result with nonzero heading");

endmodule

`default_nettype wire
